>>> hw/rtl/ucd_pkg.sv
package ucd_pkg;

  localparam int TIME_W     = 17;
  localparam int PORT_W     = 16;
  localparam int BORDER_W   = 8;
  localparam int LINE_W     = 10;
  localparam int WAIT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // frame_time plus left border needs one bit more than frame_time.
  localparam int SUM_W  = TIME_W + 1;
  localparam int REM_W  = LINE_W;
  localparam int NCELLS = SUM_W;

  localparam int PATTERN_LEN = 8;
  localparam int PHASE_W     = $clog2(PATTERN_LEN);

  localparam int IN_TDATA_W  = ((TIME_W + PORT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WAIT_W + 7) / 8) * 8;

  localparam logic [PORT_W-1:0] ULA_PORT_MASK  = 16'h0001;
  localparam logic [PORT_W-1:0] PAGE_PORT_MASK = 16'h8002;
  localparam logic [PORT_W-1:0] PORT_MATCH     = 16'h0000;

  // Contention starts this many ticks ahead of the display fetch.
  localparam int GUARD_TICKS = 3;

  localparam logic [TIME_W-1:0]   RST_DISPLAY_START = 17'd14364;
  localparam logic [TIME_W-1:0]   RST_DISPLAY_END   = 17'd58140;
  localparam logic [BORDER_W-1:0] RST_LEFT_BORDER   = 8'd24;
  localparam logic [LINE_W-1:0]   RST_TICKS_PER_LINE = 10'd228;
  localparam logic [LINE_W-1:0]   RST_SCREEN_WIDTH  = 10'd128;

  localparam logic [WAIT_W-1:0] DELAY_TABLE [PATTERN_LEN] = '{
    3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd6, 3'd5, 3'd4
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_START  = 3'd0,
    REG_DISPLAY_END    = 3'd1,
    REG_LEFT_BORDER    = 3'd2,
    REG_TICKS_PER_LINE = 3'd3,
    REG_SCREEN_WIDTH   = 3'd4
  } cfg_reg_e;

  // Data that one beat carries from cell to cell.
  typedef struct packed {
    logic [SUM_W-1:0] sum;   // frame_time + left border, kept whole
    logic [REM_W-1:0] rem;   // partial remainder of sum mod line length
    logic             hit;   // inside the display window and contended
  } ucd_lane_t;

endpackage

>>> hw/rtl/ula_contention_delay_unit.sv
// Pipeline: one entry stage, 18 remainder cells and one output register.
// Throughput: one access per cycle while m_tready does not stall the output;
// the line-position modulo is worked one dividend bit per cell along the chain,
// so every cell holds a different access.
// Reset: rst clears all valid flags and loads the register defaults; no
// clearing pass is needed and input is accepted in the first cycle after reset.
module ula_contention_delay_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata: frame_time [16:0], port_address [32:17], zero fill [39:33]
  input  logic [ucd_pkg::IN_TDATA_W-1:0]      s_tdata,
  // tuser: opcode [0] (0 memory access, 1 I/O port access)
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata: wait_ticks [2:0], zero fill [7:3]
  output logic [ucd_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [ucd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ucd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ucd_pkg::*;

  // Configuration registers; the user must write them only while the block is idle, not enforced here.
  logic [TIME_W-1:0]   display_start_time;
  logic [TIME_W-1:0]   display_end_time;
  logic [BORDER_W-1:0] left_border_ticks;
  logic [LINE_W-1:0]   ticks_per_line;
  logic [LINE_W-1:0]   screen_width_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_start_time <= RST_DISPLAY_START;
      display_end_time   <= RST_DISPLAY_END;
      left_border_ticks  <= RST_LEFT_BORDER;
      ticks_per_line     <= RST_TICKS_PER_LINE;
      screen_width_ticks <= RST_SCREEN_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_DISPLAY_START:  display_start_time <= cfg_data[TIME_W-1:0];
        REG_DISPLAY_END:    display_end_time   <= cfg_data[TIME_W-1:0];
        REG_LEFT_BORDER:    left_border_ticks  <= cfg_data[BORDER_W-1:0];
        REG_TICKS_PER_LINE: ticks_per_line     <= cfg_data[LINE_W-1:0];
        REG_SCREEN_WIDTH:   screen_width_ticks <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry stage. The access is classified here: it can only be delayed when it
  // falls inside the display window and, for an I/O access, when the port
  // decodes to the video chip (A0 low) or to the paging port (A15 and A1 low).
  // The sum that the cells reduce modulo the line length is formed here too.
  logic [TIME_W-1:0] frame_time;
  logic [PORT_W-1:0] port_address;
  logic              opcode;
  logic              in_window;
  logic              port_contended;
  ucd_lane_t         entry_next;

  assign frame_time   = s_tdata[TIME_W-1:0];
  assign port_address = s_tdata[TIME_W +: PORT_W];
  assign opcode       = s_tuser;

  always_comb begin
    in_window = (frame_time >= display_start_time) && (frame_time < display_end_time);
    port_contended = !opcode
                  || ((port_address & ULA_PORT_MASK) == PORT_MATCH)
                  || ((port_address & PAGE_PORT_MASK) == PORT_MATCH);
    entry_next.sum = SUM_W'(frame_time) + SUM_W'(left_border_ticks);
    entry_next.rem = '0;
    entry_next.hit = in_window && port_contended;
  end

  // lane[0] is the entry stage; lane[k+1] is the output of cell k.
  logic      lane_valid [NCELLS+1];
  logic      lane_ready [NCELLS+1];
  ucd_lane_t lane       [NCELLS+1];

  assign s_tready = !lane_valid[0] || lane_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid[0] <= 1'b0;
    end else if (s_tready) begin
      lane_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      lane[0] <= entry_next;
    end
  end

  // Each cell consumes one dividend bit, most significant first, so the last
  // cell holds (frame_time + left border) mod ticks_per_line.
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    ucd_cell #(
      .BIT(NCELLS - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .divisor  (ticks_per_line),
      .in_valid (lane_valid[k]),
      .in_ready (lane_ready[k]),
      .in_lane  (lane[k]),
      .out_valid(lane_valid[k+1]),
      .out_ready(lane_ready[k+1]),
      .out_lane (lane[k+1])
    );
  end

  // Output stage. A zero line length means no wrap, so the raw sum is used.
  // Both border tests are made without wrap, GUARD_TICKS ahead of the fetch.
  ucd_lane_t          last;
  logic [SUM_W-1:0]   pos;
  logic [SUM_W:0]     pos_guard;
  logic [SUM_W:0]     right_limit;
  logic               left_exempt;
  logic               right_border;
  logic [WAIT_W-1:0]  wait_next;
  logic [WAIT_W-1:0]  wait_ticks;

  assign last = lane[NCELLS];

  always_comb begin
    if (ticks_per_line == '0) begin
      pos = last.sum;
    end else begin
      pos = SUM_W'(last.rem);
    end
    pos_guard    = (SUM_W+1)'(pos) + (SUM_W+1)'(GUARD_TICKS);
    right_limit  = (SUM_W+1)'(left_border_ticks) + (SUM_W+1)'(screen_width_ticks);
    left_exempt  = pos_guard < (SUM_W+1)'(left_border_ticks);
    right_border = pos_guard >= right_limit;
    if (last.hit && !left_exempt && !right_border) begin
      wait_next = DELAY_TABLE[pos[PHASE_W-1:0]];
    end else begin
      wait_next = '0;
    end
  end

  assign lane_ready[NCELLS] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (lane_ready[NCELLS]) begin
      m_tvalid <= lane_valid[NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready[NCELLS] && lane_valid[NCELLS]) begin
      wait_ticks <= wait_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'(wait_ticks);

`ifndef SYNTHESIS
  // An accepted input beat always lands in the entry stage.
  a_entry_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> lane_valid[0])
    else $error("accepted beat did not reach the entry stage");

  // An access outside the window or to an uncontended port yields no delay.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (lane_valid[NCELLS] && lane_ready[NCELLS] && !last.hit)
      |=> (m_tvalid && (wait_ticks == '0)))
    else $error("uncontended access produced a nonzero delay");

  // The output register only fills from a beat offered by the last cell.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(m_tvalid) && m_tvalid) |-> $past(lane_valid[NCELLS]))
    else $error("output valid rose without a beat from the cell chain");
`endif

endmodule

>>> hw/rtl/ucd_cell.sv
module ucd_cell #(
  parameter int BIT = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ucd_pkg::LINE_W-1:0] divisor,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ucd_pkg::ucd_lane_t       in_lane,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ucd_pkg::ucd_lane_t       out_lane
);
  import ucd_pkg::*;

  logic [REM_W:0]   shifted;
  logic [REM_W-1:0] rem_next;
  ucd_lane_t        lane_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {in_lane.rem, in_lane.sum[BIT]};
    if (shifted >= {1'b0, divisor}) begin
      rem_next = REM_W'(shifted - {1'b0, divisor});
    end else begin
      rem_next = shifted[REM_W-1:0];
    end
    lane_next     = in_lane;
    lane_next.rem = rem_next;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_lane <= lane_next;
    end
  end

endmodule
